[rtl/bed_pkg.sv]
// Package for the backslash escape decoder: payload and state types, phase
// and status codes, and small character helper functions. No dependencies.
`timescale 1ns / 1ps

package bed_pkg;

   localparam int MaxResults = 4;

   typedef enum logic [2:0] {
      PH_PLAIN,
      PH_ESC,
      PH_HEX,
      PH_OCT,
      PH_UNI,
      PH_STOP
   } phase_type;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NO_HEX  = 2'd1;
   localparam logic [1:0] ST_BAD_CP  = 2'd2;
   localparam logic [1:0] ST_STOPPED = 2'd3;

   localparam logic [31:0] SurrLow  = 32'h0000_D800;
   localparam logic [31:0] SurrHigh = 32'h0000_DFFF;
   localparam logic [31:0] CpMax    = 32'h0010_FFFF;
   localparam logic [7:0]  EscChar  = 8'h1B;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic [1:0] status;
      logic       out_last;
   } rsp_payload_type;

   typedef struct packed {
      phase_type   phase;
      logic [3:0]  digits_seen;
      logic [31:0] accum_value;
      logic        long_unicode;
   } dec_state_type;

   // {is_hex, value}
   function automatic logic [4:0] hex_of(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= "0" && c <= "9") r = {1'b1, c[3:0]};
      else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F"))
         r = {1'b1, c[3:0] + 4'd9};
      return r;
   endfunction

   // {known, control byte} for single-letter escapes other than \c
   function automatic logic [8:0] letter_of(input logic [7:0] c);
      logic [8:0] r;
      r = 9'd0;
      case (c)
         "a":  r = {1'b1, 8'h07};
         "b":  r = {1'b1, 8'h08};
         "e":  r = {1'b1, EscChar};
         "f":  r = {1'b1, 8'h0C};
         "n":  r = {1'b1, 8'h0A};
         "r":  r = {1'b1, 8'h0D};
         "t":  r = {1'b1, 8'h09};
         "v":  r = {1'b1, 8'h0B};
         "\"": r = {1'b1, 8'h22};
         "\\": r = {1'b1, 8'h5C};
         default: r = 9'd0;
      endcase
      return r;
   endfunction

   function automatic rsp_payload_type mk_res(input logic [7:0] b, input logic v,
                                              input logic [1:0] st);
      rsp_payload_type r;
      r.out_byte   = b;
      r.byte_valid = v;
      r.status     = st;
      r.out_last   = 1'b0;
      return r;
   endfunction

endpackage

[rtl/bed_decode.sv]
// Combinational decode of one byte against the decoder state: produces up to
// four result items and the next state. Depends on bed_pkg.
`timescale 1ns / 1ps

module bed_decode import bed_pkg::*; (
   input  dec_state_type   cur_state,
   input  req_payload_type item,
   input  logic            octal_zero_mode,
   output rsp_payload_type res [MaxResults],
   output logic [2:0]      res_count,
   output dec_state_type   next_state
);

   logic [7:0]  c;
   logic [4:0]  hx;
   logic [8:0]  let_code;
   logic [7:0]  acc8;
   logic [8:0]  acc9;
   logic [31:0] cp;
   logic [3:0]  dnext;
   logic        is_oct;

   assign c        = item.in_byte;
   assign hx       = hex_of(c);
   assign let_code = letter_of(c);
   assign acc8     = {cur_state.accum_value[3:0], hx[3:0]};
   assign acc9     = {cur_state.accum_value[5:0], c[2:0]};
   assign cp       = {cur_state.accum_value[27:0], hx[3:0]};
   assign dnext    = cur_state.digits_seen + 4'd1;
   assign is_oct   = (c >= "0") && (c <= "7");

   always_comb begin
      next_state = cur_state;
      res_count  = 3'd0;
      for (int k = 0; k < MaxResults; k++) res[k] = '0;

      unique case (cur_state.phase)
         PH_PLAIN: begin
            if (c == "\\") next_state.phase = PH_ESC;
            else begin
               res[res_count[1:0]] = mk_res(c, 1'b1, ST_OK);
               res_count = res_count + 3'd1;
            end
         end
         PH_ESC: begin
            next_state.accum_value = '0;
            next_state.digits_seen = '0;
            if (c == "x") begin
               next_state.phase = PH_HEX;
            end else if (is_oct) begin
               next_state.phase = PH_OCT;
               if (!(octal_zero_mode && c == "0")) begin
                  next_state.accum_value = {29'd0, c[2:0]};
                  next_state.digits_seen = 4'd1;
               end
            end else if (c == "u" || c == "U") begin
               next_state.phase        = PH_UNI;
               next_state.long_unicode = (c == "U");
            end else if (c == "c") begin
               res[res_count[1:0]] = mk_res(8'd0, 1'b0, ST_STOPPED);
               res_count = res_count + 3'd1;
               next_state.phase = PH_STOP;
            end else if (let_code[8]) begin
               res[res_count[1:0]] = mk_res(let_code[7:0], 1'b1, ST_OK);
               res_count = res_count + 3'd1;
               next_state.phase = PH_PLAIN;
            end else begin
               // unknown escape: backslash, then the character itself
               res[res_count[1:0]] = mk_res(8'h5C, 1'b1, ST_OK);
               res_count = res_count + 3'd1;
               res[res_count[1:0]] = mk_res(c, 1'b1, ST_OK);
               res_count = res_count + 3'd1;
               next_state.phase = PH_PLAIN;
            end
         end
         PH_HEX: begin
            if (hx[4]) begin
               next_state.accum_value = {24'd0, acc8};
               next_state.digits_seen = dnext;
               if (dnext >= 4'd2) begin
                  res[res_count[1:0]] = mk_res(acc8, 1'b1, ST_OK);
                  res_count = res_count + 3'd1;
                  next_state.phase = PH_PLAIN;
               end
            end else if (cur_state.digits_seen == 4'd0) begin
               res[res_count[1:0]] = mk_res(8'd0, 1'b0, ST_NO_HEX);
               res_count = res_count + 3'd1;
               next_state.phase = PH_STOP;
            end else begin
               res[res_count[1:0]] = mk_res(cur_state.accum_value[7:0], 1'b1, ST_OK);
               res_count = res_count + 3'd1;
               next_state.phase = PH_PLAIN;
               if (c == "\\") next_state.phase = PH_ESC;
               else begin
                  res[res_count[1:0]] = mk_res(c, 1'b1, ST_OK);
                  res_count = res_count + 3'd1;
               end
            end
         end
         PH_OCT: begin
            if (is_oct) begin
               next_state.accum_value = {23'd0, acc9};
               next_state.digits_seen = dnext;
               if (dnext >= 4'd3) begin
                  res[res_count[1:0]] = mk_res(acc9[7:0], 1'b1, ST_OK);
                  res_count = res_count + 3'd1;
                  next_state.phase = PH_PLAIN;
               end
            end else begin
               res[res_count[1:0]] = mk_res(cur_state.accum_value[7:0], 1'b1, ST_OK);
               res_count = res_count + 3'd1;
               next_state.phase = PH_PLAIN;
               if (c == "\\") next_state.phase = PH_ESC;
               else begin
                  res[res_count[1:0]] = mk_res(c, 1'b1, ST_OK);
                  res_count = res_count + 3'd1;
               end
            end
         end
         PH_UNI: begin
            if (!hx[4]) begin
               res[res_count[1:0]] = mk_res(8'd0, 1'b0, ST_NO_HEX);
               res_count = res_count + 3'd1;
               next_state.phase = PH_STOP;
            end else begin
               next_state.accum_value = cp;
               next_state.digits_seen = dnext;
               if (dnext >= (cur_state.long_unicode ? 4'd8 : 4'd4)) begin
                  if ((cp >= SurrLow && cp <= SurrHigh) || cp > CpMax) begin
                     res[res_count[1:0]] = mk_res(8'd0, 1'b0, ST_BAD_CP);
                     res_count = res_count + 3'd1;
                     next_state.phase = PH_STOP;
                  end else begin
                     next_state.phase = PH_PLAIN;
                     if (cp < 32'h80) begin
                        res[0] = mk_res(cp[7:0], 1'b1, ST_OK);
                        res_count = 3'd1;
                     end else if (cp < 32'h800) begin
                        res[0] = mk_res({3'b110, cp[10:6]}, 1'b1, ST_OK);
                        res[1] = mk_res({2'b10, cp[5:0]}, 1'b1, ST_OK);
                        res_count = 3'd2;
                     end else if (cp < 32'h1_0000) begin
                        res[0] = mk_res({4'b1110, cp[15:12]}, 1'b1, ST_OK);
                        res[1] = mk_res({2'b10, cp[11:6]}, 1'b1, ST_OK);
                        res[2] = mk_res({2'b10, cp[5:0]}, 1'b1, ST_OK);
                        res_count = 3'd3;
                     end else begin
                        res[0] = mk_res({5'b11110, cp[20:18]}, 1'b1, ST_OK);
                        res[1] = mk_res({2'b10, cp[17:12]}, 1'b1, ST_OK);
                        res[2] = mk_res({2'b10, cp[11:6]}, 1'b1, ST_OK);
                        res[3] = mk_res({2'b10, cp[5:0]}, 1'b1, ST_OK);
                        res_count = 3'd4;
                     end
                  end
               end
            end
         end
         PH_STOP: next_state.phase = PH_STOP;
         default: next_state.phase = PH_STOP;
      endcase

      if (item.in_last) begin
         // end of string flushes whatever escape is still open
         case (next_state.phase)
            PH_ESC: begin
               res[res_count[1:0]] = mk_res(8'h5C, 1'b1, ST_OK);
               res_count = res_count + 3'd1;
            end
            PH_HEX: begin
               if (next_state.digits_seen == 4'd0)
                  res[res_count[1:0]] = mk_res(8'd0, 1'b0, ST_NO_HEX);
               else
                  res[res_count[1:0]] = mk_res(next_state.accum_value[7:0], 1'b1, ST_OK);
               res_count = res_count + 3'd1;
            end
            PH_OCT: begin
               res[res_count[1:0]] = mk_res(next_state.accum_value[7:0], 1'b1, ST_OK);
               res_count = res_count + 3'd1;
            end
            PH_UNI: begin
               res[res_count[1:0]] = mk_res(8'd0, 1'b0, ST_NO_HEX);
               res_count = res_count + 3'd1;
            end
            default: ;
         endcase
         next_state.phase        = PH_PLAIN;
         next_state.digits_seen  = '0;
         next_state.accum_value  = '0;
         next_state.long_unicode = 1'b0;
         if (res_count == 3'd0) begin
            res[0]    = mk_res(8'd0, 1'b0, ST_OK);
            res_count = 3'd1;
         end
         res[res_count[1:0] - 2'd1].out_last = 1'b1;
      end
   end

endmodule

[rtl/backslash_escape_decoder.sv]
// Top level of the backslash escape decoder: input register, decode, and a
// four-entry result burst buffer. Depends on bed_pkg and bed_decode.
`timescale 1ns / 1ps

//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+---------------------------------
//  req_     | in        | req_valid/req_stall| in_byte, in_last
//  rsp_     | out       | rsp_valid/rsp_stall| out_byte, byte_valid, status, out_last
//  csr_     | in        | csr_valid/csr_ready| octal_zero_mode (1 bit)
//
// A byte waits in the input register, is decoded and moves into the burst buffer,
// which drains one result per cycle while rsp_stall is low. Bytes giving zero or
// one result then sustain one transfer per cycle; after a byte giving more (UTF-8
// bursts up to four) the input holds until the last of them leaves. Zero-result
// bytes retire even while earlier results still drain. Reset is synchronous and
// returns the decoder to plain text with empty buffers; csr_ready is always high.

module backslash_escape_decoder import bed_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic            csr_data
);

   // configuration
   logic octal_zero_ff, octal_zero_in;

   // input register
   logic            in_vld_ff, in_vld_in;
   req_payload_type in_ff, in_in;

   // decoder state
   dec_state_type state_ff, state_in;

   // result burst buffer
   rsp_payload_type burst_ff [MaxResults];
   logic [2:0]      rem_ff, rem_in;
   logic [1:0]      rd_ff, rd_in;

   rsp_payload_type dec_res [MaxResults];
   logic [2:0]      dec_count;
   dec_state_type   dec_next;

   logic req_xfer, rsp_xfer, buf_free, consume, load;

   bed_decode u_decode (
      .cur_state       (state_ff),
      .item            (in_ff),
      .octal_zero_mode (octal_zero_ff),
      .res             (dec_res),
      .res_count       (dec_count),
      .next_state      (dec_next)
   );

   assign csr_ready     = 1'b1;
   assign octal_zero_in = (csr_valid && csr_ready) ? csr_data : octal_zero_ff;

   assign rsp_valid   = (rem_ff != 3'd0);
   assign rsp_payload = burst_ff[rd_ff];
   assign rsp_xfer    = rsp_valid && !rsp_stall;

   // buffer can take a new burst when empty or its final entry leaves now
   assign buf_free = (rem_ff == 3'd0) || (rem_ff == 3'd1 && rsp_xfer);
   assign consume  = in_vld_ff && ((dec_count == 3'd0) || buf_free);
   assign load     = consume && (dec_count != 3'd0);

   assign req_stall = in_vld_ff && !consume;
   assign req_xfer  = req_valid && !req_stall;

   always_comb begin
      in_vld_in = in_vld_ff;
      in_in     = in_ff;
      if (consume) in_vld_in = 1'b0;
      if (req_xfer) begin
         in_vld_in = 1'b1;
         in_in     = req_payload;
      end

      state_in = consume ? dec_next : state_ff;

      rem_in = rem_ff;
      rd_in  = rd_ff;
      if (load) begin
         rem_in = dec_count;
         rd_in  = 2'd0;
      end else if (rsp_xfer) begin
         rem_in = rem_ff - 3'd1;
         rd_in  = rd_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         octal_zero_ff <= 1'b0;
         in_vld_ff     <= 1'b0;
         state_ff      <= '{phase: PH_PLAIN, digits_seen: '0, accum_value: '0,
                            long_unicode: 1'b0};
         rem_ff        <= 3'd0;
         rd_ff         <= 2'd0;
      end else begin
         octal_zero_ff <= octal_zero_in;
         in_vld_ff     <= in_vld_in;
         state_ff      <= state_in;
         rem_ff        <= rem_in;
         rd_ff         <= rd_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff <= in_in;
      if (load) begin
         for (int k = 0; k < MaxResults; k++) burst_ff[k] <= dec_res[k];
      end
   end

   // burst never overruns the buffer
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      rem_ff <= 3'd4)
      else $error("burst count above buffer depth");

   // a new burst only replaces a drained buffer
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      load |-> (rem_ff == 3'd0 || (rem_ff == 3'd1 && rsp_xfer)))
      else $error("burst loaded over undelivered results");

   // a loaded burst is visible next cycle
   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_valid)
      else $error("loaded burst not presented");

   // a held input byte keeps its contents until decoded
   a_hold_in: assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && !consume) |=> (in_vld_ff && $stable(in_ff)))
      else $error("held input byte lost or changed");

endmodule
